// ===== rtl/core/smb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smb_pkg
// Shared constants and types of the sorted median block: buffer geometry,
// microcode control word, status word and the jump condition codes.
// ----------------------------------------------------------------------------
package smb_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SMP_W  = 16;
  localparam int MED_W  = 17;
  localparam int NCNT_W = 7;
  localparam int PC_W   = 4;

  // jump conditions
  localparam logic [3:0] C_NEXT      = 4'd0;
  localparam logic [3:0] C_ALWAYS    = 4'd1;
  localparam logic [3:0] C_NOT_VALID = 4'd2;
  localparam logic [3:0] C_FULL      = 4'd3;
  localparam logic [3:0] C_I_ZERO    = 4'd4;
  localparam logic [3:0] C_NOT_GT    = 4'd5;
  localparam logic [3:0] C_NOT_LAST  = 4'd6;
  localparam logic [3:0] C_ODD       = 4'd7;
  localparam logic [3:0] C_OUT_BUSY  = 4'd8;

  // read address select
  localparam logic [1:0] RA_I1 = 2'd0;
  localparam logic [1:0] RA_H  = 2'd1;
  localparam logic [1:0] RA_H1 = 2'd2;

  typedef struct packed {
    logic            in_rdy;
    logic [1:0]      rsel;
    logic            we;
    logic            wsel_x;
    logic            dec_i;
    logic            inc_fill;
    logic            set_drop;
    logic            ld_acc;
    logic            out_load;
    logic            add_self;
    logic [3:0]      cond;
    logic [PC_W-1:0] target;
  } smb_ctl_t;

  typedef struct packed {
    logic valid;
    logic full;
    logic i_zero;
    logic gt;
    logic last;
    logic odd;
    logic out_busy;
  } smb_stat_t;

endpackage

// ===== rtl/core/smb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smb_if
// Valid/ready channels of the sorted median block: sample input words and
// median result words.
// ----------------------------------------------------------------------------
interface smb_in_if import smb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  logic                    last_sample;

  modport source(output valid, output sample, output last_sample, input ready);
  modport sink(input valid, input sample, input last_sample, output ready);
endinterface

interface smb_out_if import smb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MED_W-1:0] median_doubled;
  logic [NCNT_W-1:0]       sample_count;
  logic                    overflow;

  modport source(output valid, output median_doubled, output sample_count,
                 output overflow, input ready);
  modport sink(input valid, input median_doubled, input sample_count,
               input overflow, output ready);
endinterface

// ===== rtl/core/sorted_median_of_block.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_median_of_block
// Median of a block of signed samples by insertion into a sorted buffer.
// ----------------------------------------------------------------------------
// in_ch carries one 16-bit signed sample per word; last_sample marks the
// final word of a block. Each sample is inserted in ascending order into a
// 64-entry buffer; samples beyond the buffer depth are dropped and flagged.
// At the block end one word leaves on out_ch: twice the median, the count
// of kept samples and the overflow flag.
// For a kept sample, each buffered sample that moves up one place takes a
// read, a compare and a write step in turn, on the separate read and write
// ports of the buffer. A dropped sample skips the insert loop. After the
// marked sample the median steps wait for a free output register.
// in_ch.ready is high only while the sequencer waits for a sample.
// Reset clears the fill count, the overflow flag, the output register valid
// and the step counter; buffer contents are never cleared.
// The result stays in the output register while out_ch.ready is low; the
// next block's samples are still taken, and the following result waits for
// the register to free up.
// ----------------------------------------------------------------------------
module sorted_median_of_block import smb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  smb_in_if.sink    in_ch,
  smb_out_if.source out_ch
);

  logic [PC_W-1:0] pc;
  smb_ctl_t        ctl;
  smb_stat_t       stat;

  smb_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .stat  (stat),
    .pc    (pc)
  );

  smb_ucode_rom u_rom (
    .pc  (pc),
    .ctl (ctl)
  );

  smb_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/core/smb_ucode_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smb_ucode_rom
// Microprogram table: one control word per step of the insert and median
// program.
// ----------------------------------------------------------------------------
module smb_ucode_rom import smb_pkg::*; (
  input  logic [PC_W-1:0] pc,
  output smb_ctl_t        ctl
);

  localparam logic [PC_W-1:0] S_WAIT   = PC_W'(0);
  localparam logic [PC_W-1:0] S_FULL   = PC_W'(1);
  localparam logic [PC_W-1:0] S_LOOP   = PC_W'(2);
  localparam logic [PC_W-1:0] S_CMP    = PC_W'(3);
  localparam logic [PC_W-1:0] S_SHIFT  = PC_W'(4);
  localparam logic [PC_W-1:0] S_PLACE  = PC_W'(5);
  localparam logic [PC_W-1:0] S_DROP   = PC_W'(6);
  localparam logic [PC_W-1:0] S_LAST   = PC_W'(7);
  localparam logic [PC_W-1:0] S_MED_A  = PC_W'(8);
  localparam logic [PC_W-1:0] S_MED_B  = PC_W'(9);
  localparam logic [PC_W-1:0] S_EVEN   = PC_W'(10);
  localparam logic [PC_W-1:0] S_ODD    = PC_W'(11);

  always_comb begin
    ctl = '0;
    case (pc)
      S_WAIT: begin
        ctl.in_rdy = 1'b1;
        ctl.cond   = C_NOT_VALID;
        ctl.target = S_WAIT;
      end
      S_FULL: begin
        ctl.cond   = C_FULL;
        ctl.target = S_DROP;
      end
      S_LOOP: begin
        ctl.rsel   = RA_I1;
        ctl.cond   = C_I_ZERO;
        ctl.target = S_PLACE;
      end
      S_CMP: begin
        ctl.cond   = C_NOT_GT;
        ctl.target = S_PLACE;
      end
      S_SHIFT: begin
        ctl.we     = 1'b1;
        ctl.dec_i  = 1'b1;
        ctl.cond   = C_ALWAYS;
        ctl.target = S_LOOP;
      end
      S_PLACE: begin
        ctl.we       = 1'b1;
        ctl.wsel_x   = 1'b1;
        ctl.inc_fill = 1'b1;
        ctl.cond     = C_ALWAYS;
        ctl.target   = S_LAST;
      end
      S_DROP: begin
        ctl.set_drop = 1'b1;
      end
      S_LAST: begin
        ctl.cond   = C_NOT_LAST;
        ctl.target = S_WAIT;
      end
      S_MED_A: begin
        ctl.rsel   = RA_H;
        ctl.cond   = C_OUT_BUSY;
        ctl.target = S_MED_A;
      end
      S_MED_B: begin
        ctl.ld_acc = 1'b1;
        ctl.rsel   = RA_H1;
        ctl.cond   = C_ODD;
        ctl.target = S_ODD;
      end
      S_EVEN: begin
        ctl.out_load = 1'b1;
        ctl.cond     = C_ALWAYS;
        ctl.target   = S_WAIT;
      end
      S_ODD: begin
        ctl.out_load = 1'b1;
        ctl.add_self = 1'b1;
        ctl.cond     = C_ALWAYS;
        ctl.target   = S_WAIT;
      end
      default: begin
        ctl.cond   = C_ALWAYS;
        ctl.target = S_WAIT;
      end
    endcase
  end

endmodule

// ===== rtl/core/smb_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smb_sequencer
// Step counter with conditional jumps chosen by the control word and the
// datapath status.
// ----------------------------------------------------------------------------
module smb_sequencer import smb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  smb_ctl_t        ctl,
  input  smb_stat_t       stat,
  output logic [PC_W-1:0] pc
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            jump;

  always_comb begin
    case (ctl.cond)
      C_NEXT:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NOT_VALID: jump = !stat.valid;
      C_FULL:      jump = stat.full;
      C_I_ZERO:    jump = stat.i_zero;
      C_NOT_GT:    jump = !stat.gt;
      C_NOT_LAST:  jump = !stat.last;
      C_ODD:       jump = stat.odd;
      C_OUT_BUSY:  jump = stat.out_busy;
      default:     jump = 1'b1;
    endcase
    pc_nxt = jump ? ctl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign pc = pc_r;

endmodule

// ===== rtl/core/smb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smb_datapath
// Sorted sample buffer with one write and one registered read port, insert
// index, fill count, median accumulator and the output register.
// ----------------------------------------------------------------------------
module smb_datapath import smb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  smb_ctl_t         ctl,
  output smb_stat_t        stat,
  smb_in_if.sink           in_ch,
  smb_out_if.source        out_ch
);

  logic signed [SMP_W-1:0] mem [DEPTH];
  logic signed [SMP_W-1:0] rd_q_r;
  logic signed [SMP_W-1:0] x_r;
  logic                    last_r;
  logic [CNT_W-1:0]        i_r;
  logic [CNT_W-1:0]        fill_r;
  logic                    drop_r;
  logic signed [MED_W-1:0] acc_r;
  logic signed [MED_W-1:0] med_r;
  logic [NCNT_W-1:0]       cnt_out_r;
  logic                    ovf_r;
  logic                    out_valid_r;

  logic                    accept;
  logic [CNT_W-1:0]        i_m1;
  logic [CNT_W-1:0]        h;
  logic [CNT_W-1:0]        h_m1;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [SMP_W-1:0] wdata;
  logic signed [MED_W-1:0] rd_ext;
  logic signed [MED_W-1:0] addend;
  logic [CNT_W+NCNT_W-1:0] cnt_ext;

  assign accept  = ctl.in_rdy && in_ch.valid;
  assign i_m1    = i_r - 1'b1;
  assign h       = fill_r >> 1;
  assign h_m1    = h - 1'b1;
  assign wdata   = ctl.wsel_x ? x_r : rd_q_r;
  assign rd_ext  = {rd_q_r[SMP_W-1], rd_q_r};
  assign addend  = ctl.add_self ? acc_r : rd_ext;
  assign cnt_ext = {{NCNT_W{1'b0}}, fill_r};

  always_comb begin
    case (ctl.rsel)
      RA_I1:   rd_addr = i_m1[IDX_W-1:0];
      RA_H:    rd_addr = h[IDX_W-1:0];
      RA_H1:   rd_addr = h_m1[IDX_W-1:0];
      default: rd_addr = i_m1[IDX_W-1:0];
    endcase
  end

  // sample buffer
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[i_r[IDX_W-1:0]] <= wdata;
    end
    rd_q_r <= mem[rd_addr];
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_ch.sample;
      last_r <= in_ch.last_sample;
      i_r    <= fill_r;
    end else if (ctl.dec_i) begin
      i_r <= i_m1;
    end
    if (ctl.ld_acc) begin
      acc_r <= rd_ext;
    end
    if (ctl.out_load) begin
      med_r     <= acc_r + addend;
      cnt_out_r <= cnt_ext[NCNT_W-1:0];
      ovf_r     <= drop_r;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.out_load) begin
        fill_r <= '0;
        drop_r <= 1'b0;
      end else begin
        if (ctl.inc_fill) begin
          fill_r <= fill_r + 1'b1;
        end
        if (ctl.set_drop) begin
          drop_r <= 1'b1;
        end
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.valid    = in_ch.valid;
  assign stat.full     = (fill_r == CNT_W'(DEPTH));
  assign stat.i_zero   = (i_r == '0);
  assign stat.gt       = (rd_q_r > x_r);
  assign stat.last     = last_r;
  assign stat.odd      = fill_r[0];
  assign stat.out_busy = out_valid_r;

  // no word is taken while in reset
  assign in_ch.ready           = ctl.in_rdy && rst_n;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.median_doubled = med_r;
  assign out_ch.sample_count   = cnt_out_r;
  assign out_ch.overflow       = ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count beyond buffer depth");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> (fill_r == '0) && !drop_r)
    else $error("block state not cleared after result");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> !out_valid_r)
    else $error("result register overwritten");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.we |-> (i_r < CNT_W'(DEPTH)))
    else $error("buffer write beyond depth");

endmodule
